// ===== sv/rsi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_pkg: shared types and constants of the ray-sphere intersection block
// payload structs for the ray/sphere item and the hit item
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int RSI_COORD_W  = 32;  // coordinate width, signed
  localparam int RSI_DIR_W    = 16;  // direction component width, signed
  localparam int RSI_DIR_FRAC = 14;  // default fractional bits of the direction

  typedef struct packed {
    logic signed [RSI_COORD_W-1:0] ray_org_x;
    logic signed [RSI_COORD_W-1:0] ray_org_y;
    logic signed [RSI_COORD_W-1:0] ray_org_z;
    logic signed [RSI_DIR_W-1:0]   ray_dir_x;
    logic signed [RSI_DIR_W-1:0]   ray_dir_y;
    logic signed [RSI_DIR_W-1:0]   ray_dir_z;
    logic signed [RSI_COORD_W-1:0] ctr_x;
    logic signed [RSI_COORD_W-1:0] ctr_y;
    logic signed [RSI_COORD_W-1:0] ctr_z;
    logic        [RSI_COORD_W-2:0] sphere_rad;
  } rsi_in_t;

  typedef struct packed {
    logic                          hit;
    logic signed [RSI_COORD_W-1:0] hit_dist;
    logic signed [RSI_COORD_W-1:0] hit_x;
    logic signed [RSI_COORD_W-1:0] hit_y;
    logic signed [RSI_COORD_W-1:0] hit_z;
  } rsi_out_t;

endpackage

// ===== sv/ray_sphere_intersect.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_sphere_intersect: pipelined ray against sphere test
// distance (root of q minus h) and hit point per item, floor root by a chain of cells
// ----------------------------------------------------------------------------
// usage
//   in_valid/in_ready/in_data carry one ray and one sphere per item,
//   out_valid/out_ready/out_data carry one hit item per input item, in order.
// throughput
//   one item per cycle; every stage holds its own item and all stages move
//   together whenever the output register is empty or being taken.
// pipeline
//   the front stages, then RW root cells, RW being the root width
//   ((QW+1)/2 root cells, 52 at the default widths), then the back end;
//   the square root chain settles one root bit per cell.
// reset
//   rst_n low clears every stage valid bit; no item is in flight afterward.
// stall
//   when out_valid is high and out_ready low the whole pipe holds and
//   in_ready drops in the same cycle; nothing is lost or repeated.
// misses give an all-zero item; distance and point saturate to 32 bits.
// ----------------------------------------------------------------------------
module ray_sphere_intersect import rsi_pkg::*; #(
  parameter int DIR_FRAC = RSI_DIR_FRAC
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rsi_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rsi_out_t out_data
);

  // widths of the exact intermediate values
  localparam int CW   = RSI_COORD_W;
  localparam int DIRW = RSI_DIR_W;
  localparam int DW   = CW + 1;            // center minus origin
  localparam int PDW  = DW + DIRW;         // dir times d
  localparam int HW   = PDW + 2;           // h, sum of three
  localparam int DDW  = 2 * DW;            // d squared
  localparam int RRW  = 2 * (CW - 1);      // radius squared
  localparam int SSW  = DDW + 2;           // |d|^2
  localparam int CCW  = SSW + 1;           // c
  localparam int HL   = (HW + 1) / 2;      // low half of |h|
  localparam int HH   = HW - HL;           // high half of |h|
  localparam int H2W  = 2 * HW;            // h squared
  localparam int CSW  = CCW + 2 * DIR_FRAC;
  localparam int QW   = ((H2W > CSW) ? H2W : CSW) + 1;
  localparam int RW   = (QW + 1) / 2;      // root width, one cell per bit
  localparam int SHW  = ((RW + 1 > HW) ? RW + 1 : HW) + 1;
  localparam int TW   = SHW - DIR_FRAC;    // t before saturation
  localparam int PTW  = TW + DIRW;         // t times dir
  localparam int PSW  = PTW - DIR_FRAC;
  localparam int HPW  = ((PSW > CW) ? PSW : CW) + 1;
  localparam int SATW = ((TW > HPW) ? TW : HPW) + 1;
  localparam int SW   = 1 + HW + 3 * CW + 3 * DIRW;

  // one enable moves every stage
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  function automatic logic signed [CW-1:0] sat(input logic signed [SATW-1:0] v);
    logic signed [SATW-1:0] hi, lo;
    hi = SATW'({1'b0, {(CW-1){1'b1}}});
    lo = -hi - SATW'(1);
    if (v > hi) begin
      sat = hi[CW-1:0];
    end else if (v < lo) begin
      sat = lo[CW-1:0];
    end else begin
      sat = v[CW-1:0];
    end
  endfunction

  // stage 1: d = center - origin
  logic                   v1_r;
  logic signed [DW-1:0]   d1x_r, d1y_r, d1z_r;
  logic signed [CW-1:0]   o1x_r, o1y_r, o1z_r;
  logic signed [DIRW-1:0] r1x_r, r1y_r, r1z_r;
  logic        [CW-2:0]   rad1_r;

  // stage 2: products
  logic                   v2_r;
  logic signed [PDW-1:0]  p2x_r, p2y_r, p2z_r;
  logic signed [DDW-1:0]  q2x_r, q2y_r, q2z_r;
  logic        [RRW-1:0]  rr2_r;
  logic signed [CW-1:0]   o2x_r, o2y_r, o2z_r;
  logic signed [DIRW-1:0] r2x_r, r2y_r, r2z_r;

  // stage 3: h and c
  logic                   v3_r;
  logic signed [HW-1:0]   h3_r;
  logic signed [CCW-1:0]  c3_r;
  logic signed [CW-1:0]   o3x_r, o3y_r, o3z_r;
  logic signed [DIRW-1:0] r3x_r, r3y_r, r3z_r;

  // stage 4: partial products of h squared
  logic                   v4_r;
  logic [2*HH-1:0]        hh4_r;
  logic [HH+HL-1:0]       hl4_r;
  logic [2*HL-1:0]        ll4_r;
  logic signed [HW-1:0]   h4_r;
  logic signed [CCW-1:0]  c4_r;
  logic signed [CW-1:0]   o4x_r, o4y_r, o4z_r;
  logic signed [DIRW-1:0] r4x_r, r4y_r, r4z_r;

  // stage 5: h squared
  logic                   v5_r;
  logic [H2W-1:0]         h25_r;
  logic signed [HW-1:0]   h5_r;
  logic signed [CCW-1:0]  c5_r;
  logic signed [CW-1:0]   o5x_r, o5y_r, o5z_r;
  logic signed [DIRW-1:0] r5x_r, r5y_r, r5z_r;

  // stage 6: discriminant q
  logic                   v6_r;
  logic signed [QW-1:0]   q6_r;
  logic signed [HW-1:0]   h6_r;
  logic signed [CW-1:0]   o6x_r, o6y_r, o6z_r;
  logic signed [DIRW-1:0] r6x_r, r6y_r, r6z_r;

  logic [HW-1:0] habs;
  assign habs = h3_r[HW-1] ? HW'(-h3_r) : HW'(h3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1x_r  <= DW'(in_data.ctr_x) - DW'(in_data.ray_org_x);
      d1y_r  <= DW'(in_data.ctr_y) - DW'(in_data.ray_org_y);
      d1z_r  <= DW'(in_data.ctr_z) - DW'(in_data.ray_org_z);
      o1x_r  <= in_data.ray_org_x;
      o1y_r  <= in_data.ray_org_y;
      o1z_r  <= in_data.ray_org_z;
      r1x_r  <= in_data.ray_dir_x;
      r1y_r  <= in_data.ray_dir_y;
      r1z_r  <= in_data.ray_dir_z;
      rad1_r <= in_data.sphere_rad;

      p2x_r <= PDW'(r1x_r) * PDW'(d1x_r);
      p2y_r <= PDW'(r1y_r) * PDW'(d1y_r);
      p2z_r <= PDW'(r1z_r) * PDW'(d1z_r);
      q2x_r <= DDW'(d1x_r) * DDW'(d1x_r);
      q2y_r <= DDW'(d1y_r) * DDW'(d1y_r);
      q2z_r <= DDW'(d1z_r) * DDW'(d1z_r);
      rr2_r <= RRW'(rad1_r) * RRW'(rad1_r);
      {o2x_r, o2y_r, o2z_r} <= {o1x_r, o1y_r, o1z_r};
      {r2x_r, r2y_r, r2z_r} <= {r1x_r, r1y_r, r1z_r};

      h3_r <= HW'(p2x_r) + HW'(p2y_r) + HW'(p2z_r);
      c3_r <= CCW'(q2x_r) + CCW'(q2y_r) + CCW'(q2z_r) - CCW'(signed'({1'b0, rr2_r}));
      {o3x_r, o3y_r, o3z_r} <= {o2x_r, o2y_r, o2z_r};
      {r3x_r, r3y_r, r3z_r} <= {r2x_r, r2y_r, r2z_r};

      // |h| in two halves keeps each multiplier narrow
      hh4_r <= (2*HH)'(habs[HW-1:HL]) * (2*HH)'(habs[HW-1:HL]);
      hl4_r <= (HH+HL)'(habs[HW-1:HL]) * (HH+HL)'(habs[HL-1:0]);
      ll4_r <= (2*HL)'(habs[HL-1:0]) * (2*HL)'(habs[HL-1:0]);
      h4_r  <= h3_r;
      c4_r  <= c3_r;
      {o4x_r, o4y_r, o4z_r} <= {o3x_r, o3y_r, o3z_r};
      {r4x_r, r4y_r, r4z_r} <= {r3x_r, r3y_r, r3z_r};

      h25_r <= (H2W'(hh4_r) << (2 * HL)) + (H2W'(hl4_r) << (HL + 1)) + H2W'(ll4_r);
      h5_r  <= h4_r;
      c5_r  <= c4_r;
      {o5x_r, o5y_r, o5z_r} <= {o4x_r, o4y_r, o4z_r};
      {r5x_r, r5y_r, r5z_r} <= {r4x_r, r4y_r, r4z_r};

      q6_r <= QW'(signed'({1'b0, h25_r})) - (QW'(c5_r) <<< (2 * DIR_FRAC));
      h6_r <= h5_r;
      {o6x_r, o6y_r, o6z_r} <= {o5x_r, o5y_r, o5z_r};
      {r6x_r, r6y_r, r6z_r} <= {r5x_r, r5y_r, r5z_r};
    end
  end

  // square root chain, one root bit per cell, most significant first
  logic            cv    [RW+1];
  logic [2*RW-1:0] cq    [RW+1];
  logic [RW+1:0]   crem  [RW+1];
  logic [RW-1:0]   croot [RW+1];
  logic [SW-1:0]   cside [RW+1];

  assign cv[0]    = v6_r;
  assign cq[0]    = (2*RW)'(q6_r[QW-2:0]);
  assign crem[0]  = '0;
  assign croot[0] = '0;
  assign cside[0] = {q6_r[QW-1], h6_r, o6x_r, o6y_r, o6z_r, r6x_r, r6y_r, r6z_r};

  for (genvar g = 0; g < RW; g++) begin : g_cell
    rsi_sqrt_cell #(
      .RW (RW),
      .SW (SW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (cv[g]),
      .q_i    (cq[g]),
      .rem_i  (crem[g]),
      .root_i (croot[g]),
      .side_i (cside[g]),
      .v_o    (cv[g+1]),
      .q_o    (cq[g+1]),
      .rem_o  (crem[g+1]),
      .root_o (croot[g+1]),
      .side_o (cside[g+1])
    );
  end

  // unpack side data at the chain end
  logic                   sneg;
  logic signed [HW-1:0]   sh_h;
  logic signed [CW-1:0]   sox, soy, soz;
  logic signed [DIRW-1:0] srx, sry, srz;
  assign {sneg, sh_h, sox, soy, soz, srx, sry, srz} = cside[RW];

  // back end: t, t times dir, point
  logic signed [SHW-1:0]  shd;
  assign shd = SHW'(signed'({1'b0, croot[RW]})) - SHW'(sh_h);

  logic                   v7_r, v8_r;
  logic                   m7_r, m8_r;
  logic signed [TW-1:0]   t7_r;
  logic signed [CW-1:0]   ts8_r;
  logic signed [PTW-1:0]  p8x_r, p8y_r, p8z_r;
  logic signed [CW-1:0]   o7x_r, o7y_r, o7z_r, o8x_r, o8y_r, o8z_r;
  logic signed [DIRW-1:0] r7x_r, r7y_r, r7z_r;
  logic                   ov_r;
  rsi_out_t               od_r, od_nxt;

  logic signed [HPW-1:0]  ptx, pty, ptz;
  assign ptx = HPW'(PSW'(p8x_r >>> DIR_FRAC)) + HPW'(o8x_r);
  assign pty = HPW'(PSW'(p8y_r >>> DIR_FRAC)) + HPW'(o8y_r);
  assign ptz = HPW'(PSW'(p8z_r >>> DIR_FRAC)) + HPW'(o8z_r);

  always_comb begin
    od_nxt = '0;
    if (!m8_r) begin
      od_nxt.hit      = 1'b1;
      od_nxt.hit_dist = ts8_r;
      od_nxt.hit_x    = sat(SATW'(ptx));
      od_nxt.hit_y    = sat(SATW'(pty));
      od_nxt.hit_z    = sat(SATW'(ptz));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      v7_r <= cv[RW];
      v8_r <= v7_r;
      ov_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // t rounds toward minus infinity
      t7_r <= TW'(shd >>> DIR_FRAC);
      m7_r <= sneg;
      {o7x_r, o7y_r, o7z_r} <= {sox, soy, soz};
      {r7x_r, r7y_r, r7z_r} <= {srx, sry, srz};

      // point uses the unsaturated t
      p8x_r <= PTW'(t7_r) * PTW'(r7x_r);
      p8y_r <= PTW'(t7_r) * PTW'(r7y_r);
      p8z_r <= PTW'(t7_r) * PTW'(r7z_r);
      ts8_r <= sat(SATW'(t7_r));
      m8_r  <= m7_r;
      {o8x_r, o8y_r, o8z_r} <= {o7x_r, o7y_r, o7z_r};

      od_r <= od_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  // ready follows the output register only
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not track output register");

  // a miss leaves every field zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |->
      (out_data.hit_dist == '0 && out_data.hit_x == '0 &&
       out_data.hit_y == '0 && out_data.hit_z == '0))
    else $error("miss item carries nonzero fields");

  // pipe is empty right after a reset edge
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !v1_r && !cv[RW]))
    else $error("item in flight after reset");

  // an accepted item advances the first stage
  a_first_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v1_r)
    else $error("accepted item lost at first stage");

endmodule

// ===== sv/rsi_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_sqrt_cell: one stage of the floor square root chain
// settles one root bit per cell and hands remainder, root and side data on
// ----------------------------------------------------------------------------
module rsi_sqrt_cell import rsi_pkg::*; #(
  parameter int RW = 52,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            v_i,
  input  logic [2*RW-1:0] q_i,
  input  logic [RW+1:0]   rem_i,
  input  logic [RW-1:0]   root_i,
  input  logic [SW-1:0]   side_i,
  output logic            v_o,
  output logic [2*RW-1:0] q_o,
  output logic [RW+1:0]   rem_o,
  output logic [RW-1:0]   root_o,
  output logic [SW-1:0]   side_o
);

  localparam int RMW = RW + 2;

  logic            v_r;
  logic [2*RW-1:0] q_r,    q_nxt;
  logic [RMW-1:0]  rem_r,  rem_nxt;
  logic [RW-1:0]   root_r, root_nxt;
  logic [SW-1:0]   side_r;
  logic [RMW+1:0]  cur, trial, diff;
  logic            ge;

  always_comb begin
    cur      = {rem_i, q_i[2*RW-1 -: 2]};
    trial    = (RMW+2)'({root_i, 2'b01});
    diff     = cur - trial;
    ge       = (cur >= trial);
    rem_nxt  = ge ? diff[RMW-1:0] : cur[RMW-1:0];
    root_nxt = {root_i[RW-2:0], ge};
    q_nxt    = {q_i[2*RW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r    <= q_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign q_o    = q_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;

endmodule

// ===== dv/rsi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_checker: hit predictor and in-order result check
// watches both channels, predicts each hit item from the accepted ray/sphere
// item with exact wide arithmetic and compares every returned item in order
// ----------------------------------------------------------------------------
module rsi_checker import rsi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  rsi_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  rsi_out_t out_data,
  output int       fail_cnt,
  output int       pending,
  output int       hit_cnt,
  output int       miss_cnt
);

  typedef logic signed [255:0] wide_t;

  rsi_out_t hit_q[$];

  function automatic wide_t sat_coord(wide_t a);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (RSI_COORD_W - 1)) - 1;
    lo = -(wide_t'(1) <<< (RSI_COORD_W - 1));
    if (a > hi) return hi;
    if (a < lo) return lo;
    return a;
  endfunction

  function automatic rsi_out_t predict_hit(rsi_in_t it);
    wide_t org[3];
    wide_t dir[3];
    wide_t dlt[3];
    wide_t h, sumsq, rad, c, q, root, cand, t;
    rsi_out_t r;
    org[0] = $signed(it.ray_org_x);
    org[1] = $signed(it.ray_org_y);
    org[2] = $signed(it.ray_org_z);
    dir[0] = $signed(it.ray_dir_x);
    dir[1] = $signed(it.ray_dir_y);
    dir[2] = $signed(it.ray_dir_z);
    dlt[0] = wide_t'($signed(it.ctr_x)) - org[0];
    dlt[1] = wide_t'($signed(it.ctr_y)) - org[1];
    dlt[2] = wide_t'($signed(it.ctr_z)) - org[2];
    rad = $signed({1'b0, it.sphere_rad});
    h = 0;
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      h = h + dir[i] * dlt[i];
      sumsq = sumsq + dlt[i] * dlt[i];
    end
    c = sumsq - rad * rad;
    q = h * h - (c <<< (2 * RSI_DIR_FRAC));
    r = '0;
    if (q < 0) return r;
    // floor root, q stays well below 2^128
    root = 0;
    for (int k = 63; k >= 0; k--) begin
      cand = root | (wide_t'(1) <<< k);
      if (cand * cand <= q) root = cand;
    end
    t = (root - h) >>> RSI_DIR_FRAC;
    r.hit = 1'b1;
    r.hit_dist = RSI_COORD_W'(sat_coord(t));
    r.hit_x = RSI_COORD_W'(sat_coord(org[0] + ((t * dir[0]) >>> RSI_DIR_FRAC)));
    r.hit_y = RSI_COORD_W'(sat_coord(org[1] + ((t * dir[1]) >>> RSI_DIR_FRAC)));
    r.hit_z = RSI_COORD_W'(sat_coord(org[2] + ((t * dir[2]) >>> RSI_DIR_FRAC)));
    return r;
  endfunction

  function automatic int check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    rsi_out_t exp_item;
    int errs;
    if (!rst_n) begin
      fail_cnt <= 0;
      hit_cnt  <= 0;
      miss_cnt <= 0;
    end else begin
      if (in_valid && in_ready) hit_q.push_back(predict_hit(in_data));
      if (out_valid && out_ready) begin
        if (hit_q.size() == 0) begin
          $display("%0t: unexpected item %h", $time, out_data);
          fail_cnt <= fail_cnt + 1;
        end else begin
          exp_item = hit_q.pop_front();
          errs = check_field("hit", 32'(exp_item.hit), 32'(out_data.hit))
               + check_field("hit_dist", exp_item.hit_dist, out_data.hit_dist)
               + check_field("hit_x", exp_item.hit_x, out_data.hit_x)
               + check_field("hit_y", exp_item.hit_y, out_data.hit_y)
               + check_field("hit_z", exp_item.hit_z, out_data.hit_z);
          if (errs != 0) fail_cnt <= fail_cnt + 1;
          if (exp_item.hit) hit_cnt <= hit_cnt + 1;
          else miss_cnt <= miss_cnt + 1;
        end
      end
    end
  end

  assign pending = hit_q.size();

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: ray-sphere intersection testbench
// directed corner items then random rays and spheres, with random idling on
// both channels; the checker predicts and compares every hit item
// ----------------------------------------------------------------------------
module tb import rsi_pkg::*; ();

  localparam int N_RANDOM = 1200;
  localparam logic signed [31:0] C_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] C_MIN = 32'sh80000000;
  localparam logic signed [15:0] D_ONE = 16'sd16384;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  rsi_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  rsi_out_t out_data;

  int fail_cnt, pending, hit_cnt, miss_cnt;
  int sent_cnt;
  logic idle_on;   // cleared for the tail of the run
  logic in_fire;   // item taken at the last rising edge

  ray_sphere_intersect u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  rsi_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .fail_cnt (fail_cnt),
    .pending  (pending),
    .hit_cnt  (hit_cnt),
    .miss_cnt (miss_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // handshake seen with pre-edge values, read back at the falling edge
  always @(posedge clk) begin
    in_fire <= in_valid && in_ready;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("tb failed");
    $finish;
  end

  // build one item from its parts
  function automatic rsi_in_t mk_item(logic signed [31:0] ox, logic signed [31:0] oy,
                                      logic signed [31:0] oz, logic signed [15:0] dx,
                                      logic signed [15:0] dy, logic signed [15:0] dz,
                                      logic signed [31:0] cx, logic signed [31:0] cy,
                                      logic signed [31:0] cz, logic [30:0] rad);
    rsi_in_t it;
    it.ray_org_x = ox;  it.ray_org_y = oy;  it.ray_org_z = oz;
    it.ray_dir_x = dx;  it.ray_dir_y = dy;  it.ray_dir_z = dz;
    it.ctr_x = cx;      it.ctr_y = cy;      it.ctr_z = cz;
    it.sphere_rad = rad;
    return it;
  endfunction

  // drive one item at the falling edge and hold it until taken
  task automatic send_item(rsi_in_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_data  = it;
    in_valid = 1'b1;
    do @(negedge clk); while (!in_fire);
    sent_cnt++;
  endtask

  // sphere placed near a short ray, mostly hits, some misses
  function automatic rsi_in_t near_item();
    logic signed [31:0] o[3];
    logic signed [15:0] d[3];
    int ax;
    for (int i = 0; i < 3; i++) begin
      o[i] = $signed($urandom_range(0, 32'h3ff_ffff)) - 32'sh1ff_ffff;
      d[i] = $signed(16'($urandom_range(0, 22000))) - 16'sd11000;
    end
    if ($urandom_range(0, 2) == 0) begin
      // axis ray with a true unit direction
      ax = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) d[i] = 0;
      d[ax] = $urandom_range(0, 1) ? D_ONE : -D_ONE;
    end
    return mk_item(o[0], o[1], o[2], d[0], d[1], d[2],
                   o[0] + $signed($urandom_range(0, 32'h3f_ffff)) - 32'sh1f_ffff,
                   o[1] + $signed($urandom_range(0, 32'h3f_ffff)) - 32'sh1f_ffff,
                   o[2] + $signed($urandom_range(0, 32'h3f_ffff)) - 32'sh1f_ffff,
                   31'($urandom_range(0, 32'h7f_ffff)));
  endfunction

  // arbitrary bits everywhere
  function automatic rsi_in_t noise_item();
    return mk_item($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                   16'($urandom), $urandom, $urandom, $urandom, 31'($urandom));
  endfunction

  // result side stalls in bursts while idling is on
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      out_ready = 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  initial begin
    rsi_in_t dir_list[$];
    int wait_cnt;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    idle_on  = 1'b1;
    sent_cnt = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: degenerate sphere, plain hit, miss, behind origin, extremes
    dir_list.push_back(mk_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_list.push_back(mk_item(0, 0, 0, D_ONE, 0, 0, 32'sh50000, 0, 0, 31'h10000));
    dir_list.push_back(mk_item(0, 0, 0, D_ONE, 0, 0, 32'sh50000, 32'sh50000, 0, 31'h10000));
    dir_list.push_back(mk_item(0, 0, 0, 0, D_ONE, 0, 0, -32'sh80000, 0, 31'h20000));
    dir_list.push_back(mk_item(0, 0, 0, 0, 0, -D_ONE, 0, 0, 32'sh30000, 31'h8000));
    dir_list.push_back(mk_item(C_MAX, C_MAX, C_MAX, D_ONE, D_ONE, D_ONE,
                               C_MIN, C_MIN, C_MIN, 31'h7fffffff));
    dir_list.push_back(mk_item(C_MIN, C_MIN, C_MIN, -D_ONE, -D_ONE, -D_ONE,
                               C_MAX, C_MAX, C_MAX, 31'h7fffffff));
    dir_list.push_back(mk_item(C_MAX, C_MIN, 0, 16'sh8000, 16'sh8000, 16'sh8000,
                               C_MAX, C_MIN, 0, 31'h7fffffff));
    dir_list.push_back(mk_item(0, 0, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                               C_MAX, C_MAX, C_MAX, 31'h7fffffff));
    dir_list.push_back(mk_item(0, 0, 0, 16'sh8000, 0, 0, 0, 0, 0, 31'h7fffffff));
    dir_list.push_back(mk_item(C_MAX, 0, 0, D_ONE, 0, 0, C_MAX, 0, 0, 31'h7fffffff));
    dir_list.push_back(mk_item(C_MIN, 0, 0, -D_ONE, 0, 0, C_MIN, 0, 0, 31'h7fffffff));
    dir_list.push_back(mk_item(0, 0, 0, 16'sd8000, 16'sd8000, 0, 0, 0, 0, 31'h40000));
    dir_list.push_back(mk_item(0, 0, 0, 0, 0, 0, C_MAX, 0, 0, 31'h1));
    dir_list.push_back(mk_item(-1, -1, -1, 16'shffff, 16'shffff, 16'shffff,
                               -1, -1, -1, 31'h7fffffff));
    foreach (dir_list[i]) send_item(dir_list[i]);

    // random: mostly spheres near the ray, the rest raw bits
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - 150) idle_on = 1'b0;
      if ($urandom_range(0, 9) < 7) send_item(near_item());
      else send_item(noise_item());
    end
    in_valid = 1'b0;

    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (100) @(posedge clk);

    $display("sent %0d ray/sphere items, %0d came back as hits and %0d as misses",
             sent_cnt, hit_cnt, miss_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d bad items, %0d never returned", fail_cnt, pending);
      $display("tb failed");
    end
    $finish;
  end

endmodule
